[hdl/exk_pkg.sv]
// Shared constants for the exact-k odd subarray counter.
// No dependencies; imported by the core and its test bench.
`timescale 1ns / 1ps
`default_nettype none

package exk_pkg;

    localparam int ELEM_W      = 32;   // element width on s_tdata
    localparam int K_W         = 8;    // width of the target_odds register
    localparam int COUNT_W     = 32;   // width of nice_count
    localparam int SEEN_W      = 9;    // saturating odd counter
    localparam int RING_DEPTH  = 256;  // recent odd positions kept
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int MAX_LEN_DEF = 65536;
    localparam int K_MAX_DEF   = 255;

    localparam logic [SEEN_W-1:0] ODD_SAT  = '1;
    localparam logic [K_W-1:0]    K_RESET  = 8'd1;

endpackage : exk_pkg

`default_nettype wire

[hdl/exact_k_odd_subarray_counter_core.sv]
// A last element passes stage 1, then the output register, to reach m_tvalid.
// Throughput: one element per cycle; the ring RAM takes a write for each odd
// element and two reads per element; the total's adder feeds its register.
// Input stalls only while a second result waits behind an untaken one.
// Reset (aresetn low, synchronous) clears counters, total, pipeline and output
// valid, and sets target_odds to 1; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module exact_k_odd_subarray_counter_core #(
    parameter int MAX_LEN = exk_pkg::MAX_LEN_DEF,
    parameter int K_MAX   = exk_pkg::K_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration: target_odds
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [exk_pkg::K_W-1:0]     cfg_data,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [exk_pkg::ELEM_W-1:0]  s_tdata,   // [31:0] element
    input  wire logic                        s_tlast,   // last element of the array
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [exk_pkg::COUNT_W-1:0] m_tdata,   // [31:0] nice_count
    output logic                             m_tuser    // [0] length_overflow
);

    import exk_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             ovf;
        logic             add_en;
        logic             far_zero;
        logic             near_fwd;
        logic [POS_W-1:0] pos;
    } stage_t;

    logic [K_W-1:0]     k_reg;
    logic [POS_W-1:0]   position_reg,  position_next;
    logic [SEEN_W-1:0]  odd_seen_reg,  odd_seen_next;
    logic [RING_AW-1:0] ring_head_reg, ring_head_next;
    logic               overflowed_reg, overflowed_next;
    logic [COUNT_W-1:0] total_reg,     total_next;
    stage_t             p1_reg,        p1_next;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_ovf_reg;

    logic               s_accept;
    logic               advance;
    logic               out_load;
    logic               odd;
    logic               in_range;
    logic               k_ok;
    logic               ram_we;
    logic [RING_AW-1:0] addr_near, addr_far;
    logic [POS_W-1:0]   ram_near, ram_far;
    logic [POS_W-1:0]   near_pos, far_pos;
    logic [COUNT_W-1:0] delta;
    logic [COUNT_W-1:0] sum;
    logic [SEEN_W-1:0]  k_plus;

    assign cfg_ready = 1'b1;

    // stage 1 moves on unless it holds a result and the output is still full
    assign advance  = !p1_reg.valid || !p1_reg.last || !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = advance && p1_reg.valid && p1_reg.last;

    assign odd      = s_tdata[0];
    assign in_range = position_reg < POS_W'(MAX_LEN);
    assign k_ok     = (k_reg != '0) && (int'(k_reg) <= K_MAX);
    assign k_plus   = {1'b0, k_reg} + SEEN_W'(1);

    // element bookkeeping in the accept cycle
    always_comb begin
        position_next   = position_reg;
        odd_seen_next   = odd_seen_reg;
        ring_head_next  = ring_head_reg;
        overflowed_next = overflowed_reg;
        if (in_range) begin
            position_next = position_reg + POS_W'(1);
            if (odd) begin
                ring_head_next = ring_head_reg + RING_AW'(1);
                if (odd_seen_reg != ODD_SAT) begin
                    odd_seen_next = odd_seen_reg + SEEN_W'(1);
                end
            end
        end else begin
            overflowed_next = 1'b1;
        end
    end

    assign addr_near = ring_head_next - k_reg;
    assign addr_far  = ring_head_next - k_reg - RING_AW'(1);
    assign ram_we    = s_accept && in_range && odd;

    always_comb begin
        p1_next          = p1_reg;
        if (advance) begin
            p1_next.valid    = s_accept;
            p1_next.last     = s_tlast;
            p1_next.ovf      = overflowed_next;
            p1_next.add_en   = in_range && k_ok && (odd_seen_next >= {1'b0, k_reg});
            p1_next.far_zero = odd_seen_next < k_plus;
            // with k of one the nearest odd is the one written this cycle
            p1_next.near_fwd = odd && (k_reg == K_W'(1));
            p1_next.pos      = position_next;
        end
    end

    exk_ram #(
        .WIDTH (POS_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ring_head_reg),
        .wr_data   (position_next),
        .rd_en     (s_accept),
        .rd_addr_a (addr_near),
        .rd_addr_b (addr_far),
        .rd_data_a (ram_near),
        .rd_data_b (ram_far)
    );

    assign near_pos = p1_reg.near_fwd ? p1_reg.pos : ram_near;
    assign far_pos  = p1_reg.far_zero ? '0 : ram_far;
    assign delta    = p1_reg.add_en
                    ? (COUNT_W'(near_pos) - COUNT_W'(far_pos)) : '0;
    assign sum      = total_reg + delta;

    always_comb begin
        total_next = total_reg;
        if (advance && p1_reg.valid) begin
            total_next = p1_reg.last ? '0 : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg          <= K_RESET;
            position_reg   <= '0;
            odd_seen_reg   <= '0;
            ring_head_reg  <= '0;
            overflowed_reg <= 1'b0;
            total_reg      <= '0;
            p1_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                k_reg <= cfg_data;
            end
            if (s_accept) begin
                if (s_tlast) begin
                    position_reg   <= '0;
                    odd_seen_reg   <= '0;
                    ring_head_reg  <= '0;
                    overflowed_reg <= 1'b0;
                end else begin
                    position_reg   <= position_next;
                    odd_seen_reg   <= odd_seen_next;
                    ring_head_reg  <= ring_head_next;
                    overflowed_reg <= overflowed_next;
                end
            end
            p1_reg    <= p1_next;
            total_reg <= total_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_count_reg <= sum;
            out_ovf_reg   <= p1_reg.ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten");

    // a last element leaves the element counters cleared
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (position_reg == '0 && odd_seen_reg == '0
                                   && ring_head_reg == '0))
        else $error("state not cleared after last element");

    // position never runs past the length bound
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= POS_W'(MAX_LEN))
        else $error("position beyond maximum length");

    // a result reaches the output in the cycle after its last element leaves stage 1
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result lost after load");
`endif

endmodule : exact_k_odd_subarray_counter_core

`default_nettype wire

[hdl/exk_ram.sv]
// Generic simple dual-read RAM: one write port, two registered read ports.
// Standalone; used for the odd position ring of the counter core.
`timescale 1ns / 1ps
`default_nettype none

module exk_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read returns the old contents on a same-cycle write
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule : exk_ram

`default_nettype wire

[sim/exact_k_odd_subarray_counter_core_test.sv]
// Self-checking bench for exact_k_odd_subarray_counter_core: streams arrays of elements,
// predicts each nice_count and length_overflow, and checks the results in order.
// Depends on exk_pkg and the core RTL, which also uses exk_ram.
`timescale 1ns / 1ps

module exact_k_odd_subarray_counter_core_test;
    import exk_pkg::*;

    localparam int MAX_LEN      = MAX_LEN_DEF;
    localparam int K_MAX        = K_MAX_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 70;
    localparam int NUM_PHASES   = 10;

    typedef struct {
        logic [ELEM_W-1:0] element;
        logic              is_last;
    } elem_t;

    typedef struct {
        logic [COUNT_W-1:0] nice_count;
        logic               length_overflow;
    } tally_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [K_W-1:0]      cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [ELEM_W-1:0]   s_tdata   = '0;   // [31:0] element
    logic                s_tlast   = 1'b0; // last element of the array
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [COUNT_W-1:0]  m_tdata;          // [31:0] nice_count
    logic                m_tuser;          // [0] length_overflow

    // predictor state
    logic [K_W-1:0]      target_k  = K_RESET;
    logic [16:0]         elem_pos  = '0;
    logic [SEEN_W-1:0]   odds_seen = '0;
    logic [16:0]         odd_pos_ring [RING_DEPTH];
    logic [RING_AW-1:0]  ring_wr   = '0;
    logic [COUNT_W-1:0]  total     = '0;
    logic                too_long  = 1'b0;

    elem_t  pending_elems[$];
    tally_t expected_tallies[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    exact_k_odd_subarray_counter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_tally();
        elem_pos  = '0;
        odds_seen = '0;
        ring_wr   = '0;
        total     = '0;
        too_long  = 1'b0;
    endfunction

    // n-th most recent odd position; zero when n is zero or above the ring depth, or fewer than n odds are held
    function automatic logic [16:0] nth_recent_odd(input int n);
        if (n == 0 || int'(odds_seen) < n || n > RING_DEPTH) begin
            return '0;
        end
        return odd_pos_ring[RING_AW'(int'(ring_wr) - n)];
    endfunction

    function automatic void count_element(input elem_t e);
        logic [16:0] near_pos;
        logic [16:0] far_pos;
        if (elem_pos >= 17'(MAX_LEN)) begin
            too_long = 1'b1;    // drop the element beyond the length bound
        end else begin
            elem_pos = elem_pos + 17'd1;
            if (e.element[0]) begin
                odd_pos_ring[ring_wr] = elem_pos;
                ring_wr = ring_wr + 1'b1;
                if (odds_seen != ODD_SAT) begin
                    odds_seen = odds_seen + 1'b1;
                end
            end
            if (target_k >= 1 && target_k <= K_MAX && odds_seen >= target_k) begin
                near_pos = nth_recent_odd(int'(target_k));
                far_pos  = nth_recent_odd(int'(target_k) + 1);
                total    = total + COUNT_W'(near_pos - far_pos);
            end
        end
        if (e.is_last) begin
            expected_tallies.insert(expected_tallies.size(), tally_t'{total, too_long});
            clear_tally();
        end
    endfunction

    function automatic void push_elem(input logic [ELEM_W-1:0] value, input logic is_last);
        pending_elems.insert(pending_elems.size(), elem_t'{value, is_last});
    endfunction

    function automatic void push_array(input int len, input int odd_pct);
        logic [ELEM_W-1:0] value;
        for (int i = 0; i < len; i++) begin
            value    = $urandom;
            value[0] = ($urandom_range(99) < odd_pct);
            push_elem(value, i == len - 1);
        end
    endfunction

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default: begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_elems.size() != 0 || s_tvalid || expected_tallies.size() != 0) begin
            @(posedge aclk);
        end
        // let the pipeline empty behind the last result
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_target(input logic [K_W-1:0] k);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        target_k = k;
        @(negedge aclk);
    endtask

    // driver: predict on each accepted transaction, then present the next one
    always @(posedge aclk) begin : drive
        elem_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                count_element(elem_t'{s_tdata, s_tlast});
            end
            if (!s_tvalid || s_tready) begin
                if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_elems.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.element;
                    s_tlast  <= nxt.is_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest expected tally
    always @(posedge aclk) begin : check
        tally_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tallies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result nice_count=%0d length_overflow=%0b",
                                 $time, m_tdata, m_tuser);
                    end
                end else begin
                    want = expected_tallies.pop_front();
                    if (m_tdata !== want.nice_count || m_tuser !== want.length_overflow) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: nice_count exp %0d got %0d, length_overflow exp %0b got %0b",
                                     $time, want.nice_count, m_tdata,
                                     want.length_overflow, m_tuser);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** exact_k_odd_subarray_counter_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [K_W-1:0] phase_k [NUM_PHASES];
        int pushed;
        int len;
        phase_k = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd2, 8'd6, 8'd200, 8'd1, 8'd13, 8'd4};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset target: single-element arrays, then field extremes and negative odds
        push_elem(32'h0000_0001, 1'b1);
        push_elem(32'h0000_0000, 1'b1);
        push_elem(32'h7FFF_FFFF, 1'b0);
        push_elem(32'h8000_0000, 1'b0);
        push_elem(32'hFFFF_FFFF, 1'b0);
        push_elem(32'h8000_0001, 1'b0);
        push_elem(32'hFFFF_FFFE, 1'b1);

        // change the target halfway through an array
        push_elem(32'h0000_0005, 1'b0);
        push_elem(32'h0000_0004, 1'b0);
        push_elem(32'h0000_0007, 1'b0);
        write_target(8'd2);
        push_elem(32'h0000_0009, 1'b0);
        push_elem(32'h0000_0006, 1'b0);
        push_elem(32'h0000_000B, 1'b1);

        // zero target counts nothing
        write_target(8'd0);
        push_elem(32'h0000_0003, 1'b0);
        push_elem(32'h0000_0005, 1'b0);
        push_elem(32'h0000_0007, 1'b0);
        push_elem(32'hFFFF_FFFF, 1'b1);

        // largest target with too few odds
        write_target(8'd255);
        push_elem(32'h0000_0001, 1'b0);
        push_elem(32'h0000_0003, 1'b0);
        push_elem(32'h0000_0005, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_target(phase_k[ph]);
            set_idling(ph % 4);
            pushed = 0;
            if (phase_k[ph] == 8'd255) begin
                len = 600;   // push the odd counter into saturation
                push_array(len, 100);
                pushed += len;
            end else if (phase_k[ph] > 8'd32) begin
                len = phase_k[ph] + $urandom_range(20, 80);
                push_array(len, 90);
                pushed += len;
                len = phase_k[ph] + $urandom_range(0, 40);
                push_array(len, 100);
                pushed += len;
            end
            while (pushed < PHASE_ITEMS) begin
                len = $urandom_range(1, 24);
                push_array(len, $urandom_range(0, 4) * 25);
                pushed += len;
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("** exact_k_odd_subarray_counter_core: PASSED **");
        end else begin
            $display("** exact_k_odd_subarray_counter_core: FAILED **");
        end
        $finish;
    end

endmodule
